>>> rtl/ibo_pkg.sv
// Shared constants, types and helpers for the interval booking overlap checker.
package ibo_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int TIME_BITS = 30;
    localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int STAT_W    = 2;

    localparam logic [STAT_W-1:0] STAT_BOOKED   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_CONFLICT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, restart scan
        logic rd;       // read slot at scan pointer, advance pointer
        logic emit;     // load result register
        logic store;    // append request to table
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;  // pointer reached the fill count
        logic rd_pend;   // a read is in flight to the comparator
        logic clash;     // comparator hit this cycle
        logic hit;       // request already found to conflict
        logic full;      // table holds MAX_SLOTS entries
        logic out_free;  // result register can take a new result
    } t_sts;

    // Half-open intervals [a,b) vs [s,e).
    function automatic logic ibo_clash(t_time a, t_time b, t_time s, t_time e);
        logic inside_stored;
        logic covers_start;
        inside_stored = (a >= s) && (a < e);
        covers_start  = (a <= s) && (b > s);
        return inside_stored || covers_start;
    endfunction

endpackage

>>> rtl/ibo_ctrl.sv
// Controller state machine: accept, scan, decide and emit.
module ibo_ctrl import ibo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_sts i_sts,
    output logic o_req_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // stop on the first clash, or once the last compare has drained
                if (i_sts.clash || (i_sts.scan_end && !i_sts.rd_pend)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_SCAN: begin
                o_cmd.rd = !i_sts.scan_end && !i_sts.clash;
            end
            S_DONE: begin
                o_cmd.emit  = i_sts.out_free;
                o_cmd.store = i_sts.out_free && !i_sts.hit && !i_sts.full;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/ibo_dp.sv
// Datapath: interval table, scan pointer, comparator and result register.
module ibo_dp import ibo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_time             i_req_start,
    input  t_time             i_req_end,
    input  logic              i_rsp_ready,
    output t_sts              o_sts,
    output logic              o_rsp_valid,
    output logic [STAT_W-1:0] o_status
);

    t_time r_mem_s [MAX_SLOTS];
    t_time r_mem_e [MAX_SLOTS];

    t_time             r_a;
    t_time             r_b;
    t_time             r_rd_s;
    t_time             r_rd_e;
    logic              r_rd_vld;
    logic              r_hit;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic              r_out_vld;
    logic [STAT_W-1:0] r_status;

    logic              clash;
    logic              full;
    logic [STAT_W-1:0] n_status;

    assign clash = r_rd_vld && ibo_clash(r_a, r_b, r_rd_s, r_rd_e);
    assign full  = (r_count == CNT_MAX);

    always_comb begin
        if (r_hit) begin
            n_status = STAT_CONFLICT;
        end else if (full) begin
            n_status = STAT_FULL;
        end else begin
            n_status = STAT_BOOKED;
        end
    end

    // table storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem_s[r_count[SLOT_AW-1:0]] <= r_a;
            r_mem_e[r_count[SLOT_AW-1:0]] <= r_b;
        end
        if (i_cmd.rd) begin
            r_rd_s <= r_mem_s[r_idx[SLOT_AW-1:0]];
            r_rd_e <= r_mem_e[r_idx[SLOT_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_req_start;
            r_b <= i_req_end;
        end
        if (i_cmd.emit) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_count   <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
                r_idx <= '0;
            end else begin
                if (clash) begin
                    r_hit <= 1'b1;
                end
                if (i_cmd.rd) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.store) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.scan_end = (r_idx == r_count);
    assign o_sts.rd_pend  = r_rd_vld;
    assign o_sts.clash    = clash;
    assign o_sts.hit      = r_hit;
    assign o_sts.full     = full;
    assign o_sts.out_free = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid = r_out_vld;
    assign o_status    = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("fill count beyond table depth");

    a_store_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (!r_hit && !full && i_cmd.emit))
        else $error("store of conflicting request or into full table");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_idx < r_count))
        else $error("read past stored entries");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_vld || i_rsp_ready))
        else $error("result register overwritten before taken");

endmodule

>>> rtl/interval_booking_overlap_check.sv
// An accepted request passes through the scan and done states before its result is raised;
// with stored intervals and no clash the scan reads one entry per cycle.
// Throughput: one request at a time, set by the single-port table scan;
// a new request is taken while the last result waits.
// Reset: synchronous active-low clears the fill count, controller and result valid;
// table contents are not cleared, only entries below the fill count are read.
module interval_booking_overlap_check import ibo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [TIME_BITS-1:0] i_req_start,
    input  logic [TIME_BITS-1:0] i_req_end,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic [STAT_W-1:0] o_status
);

    t_cmd cmd;
    t_sts sts;

    ibo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_sts       (sts),
        .o_req_ready (o_req_ready),
        .o_cmd       (cmd)
    );

    ibo_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req_start (i_req_start),
        .i_req_end   (i_req_end),
        .i_rsp_ready (i_rsp_ready),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .o_status    (o_status)
    );

endmodule

>>> sim/testbench.sv
// Self-checking bench for the interval booking checker: predicts the status of every request.
module testbench;
    import ibo_pkg::*;

    localparam t_time TIME_TOP = {TIME_BITS{1'b1}};

    logic              i_clk;
    logic              i_rst_n;
    logic              i_req_valid;
    logic              o_req_ready;
    t_time             i_req_start;
    t_time             i_req_end;
    logic              o_rsp_valid;
    logic              i_rsp_ready;
    logic [STAT_W-1:0] o_status;

    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;

    interval_booking_overlap_check uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req_start (i_req_start),
        .i_req_end   (i_req_end),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_status    (o_status)
    );

    class booking_scoreboard;
        t_time             booked_start[MAX_SLOTS];
        t_time             booked_end[MAX_SLOTS];
        int unsigned       booked_count;
        logic [STAT_W-1:0] status_due[$];
        int unsigned       mismatches;

        function new();
            booked_count = 0;
            mismatches   = 0;
        endfunction

        // Predict the status of an accepted request and book it when it fits.
        function void note(t_time a, t_time b);
            bit                hit;
            logic [STAT_W-1:0] st;
            hit = 0;
            for (int i = 0; i < booked_count && !hit; i++) begin
                if ((a >= booked_start[i] && a < booked_end[i]) ||
                    (a <= booked_start[i] && b > booked_start[i]))
                    hit = 1;
            end
            if (hit) begin
                st = STAT_CONFLICT;
            end else if (booked_count >= MAX_SLOTS) begin
                st = STAT_FULL;
            end else begin
                booked_start[booked_count] = a;
                booked_end[booked_count]   = b;
                booked_count++;
                st = STAT_BOOKED;
            end
            status_due = {status_due, st};
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check(logic [STAT_W-1:0] got);
            logic [STAT_W-1:0] want;
            if (status_due.size() == 0) begin
                report($sformatf("status %0d with no request outstanding", got));
            end else begin
                want = status_due.pop_front();
                if (got !== want)
                    report($sformatf("status %0d, predicted %0d", got, want));
            end
        endtask

        function void pick(output t_time s, output t_time e);
            int unsigned k;
            k = $urandom_range(0, booked_count - 1);
            s = booked_start[k];
            e = booked_end[k];
        endfunction
    endclass

    booking_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Runaway guard, far beyond every request scanning a full table under stalls.
    initial begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

    // Mostly short intervals in a crowded window and around booked edges, plus wide, empty and reversed noise.
    function automatic void make_request(output t_time a, output t_time b);
        int unsigned kind;
        t_time       s;
        t_time       e;
        t_time       len;
        kind = $urandom_range(0, 99);
        len  = t_time'($urandom_range(1, 500));
        if (kind < 35) begin
            a = t_time'($urandom_range(0, 16383));
            b = a + len;
        end else if (kind < 60 && sb.booked_count > 0) begin
            sb.pick(s, e);
            case ($urandom_range(0, 5))
                0: begin a = e;        b = e + len;  end
                1: begin a = s - len;  b = s;        end
                2: begin a = s;        b = s + len;  end
                3: begin a = s - len;  b = s + 1'b1; end
                4: begin a = e - 1'b1; b = e + len;  end
                default: begin a = s + 1'b1; b = s + 2'd2; end
            endcase
        end else if (kind < 85) begin
            a = t_time'($urandom);
            b = a + t_time'($urandom_range(1, 65535));
        end else if (kind < 93) begin
            a = t_time'($urandom);
            b = ($urandom_range(0, 1) != 0) ? a : a - len;
        end else begin
            a = t_time'($urandom);
            b = t_time'($urandom);
        end
    endfunction

    // Offer one request after a random gap; return at the edge that accepts it.
    task automatic send_req(input t_time a, input t_time b);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req_start <= a;
        i_req_end   <= b;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note(a, b);
    endtask

    task automatic send_random(input int unsigned count);
        t_time a;
        t_time b;
        repeat (count) begin
            make_request(a, b);
            send_req(a, b);
        end
    endtask

    // Drop the request line and wait for every outstanding result.
    task automatic drain();
        i_req_valid <= 1'b0;
        while (sb.status_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Response side: random back-pressure and one long hold-off early on.
    initial begin
        int unsigned seen;
        int unsigned hold_left;
        bit          held;
        seen      = 0;
        hold_left = 0;
        held      = 0;
        i_rsp_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
                sb.check(o_status);
                seen++;
            end
            if (!held && seen == 40) begin
                held      = 1;
                hold_left = 800;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        snd_idle_pct = 27;
        rcv_idle_pct = 52;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req_start <= '0;
        i_req_end   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, empty and reversed intervals, touching edges, extremes.
        send_req(0, 0);
        send_req(0, 1);
        send_req(TIME_TOP, TIME_TOP);
        send_req(100, 200);
        send_req(150, 160);
        send_req(50, 100);
        send_req(200, 300);
        send_req(99, 101);
        send_req(199, 250);
        send_req(500, 400);
        send_req(450, 460);
        send_req(490, 510);
        send_req(TIME_TOP - 1'b1, TIME_TOP);
        send_req(30'h2AAA_AAAA, 30'h1555_5555);
        send_req(30'h1555_5555, 30'h2AAA_AAAA);
        send_req(0, TIME_TOP);
        send_req(1000, 1000);
        send_req(1000, 1001);
        send_req(TIME_TOP, 0);

        send_random(180);
        drain();

        snd_idle_pct = 52;
        rcv_idle_pct = 27;
        send_random(180);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_random(200);
        drain();

        repeat (MAX_SLOTS + 8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/ibo_pkg.sv
rtl/ibo_ctrl.sv
rtl/ibo_dp.sv
rtl/interval_booking_overlap_check.sv
sim/testbench.sv
